/* rtl/core/assert_macros.svh */
// Assertion macros shared by the decoder RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on clk, ignored while rst_n is low.
`define PUD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on clk at every edge, reset included.
`define PUD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PUD_ASSERT(lbl, prop, msg)
`define PUD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/core/pud_pkg.sv */
// Types, character constants and helpers for the percent URL decoder.
package pud_pkg;

  localparam int ENTITY_MAX_DEF = 2;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_t;

  // Results of one step: count, then bytes in emission order
  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
  } res_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // Returns {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      r = {1'b1, c[3:0]};
    end else if (((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66))) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

/* rtl/core/pud_core.sv */
// Escape state and per-byte decode logic of the percent URL decoder.
`include "assert_macros.svh"
module pud_core
  import pud_pkg::*;
#(
  parameter int ENTITY_MAX = ENTITY_MAX_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  in_t  item,
  output res_t res
);

  localparam int CntW = $clog2(ENTITY_MAX + 1);

  logic            pend_r, pend_nxt;
  logic [CntW-1:0] dc_r, dc_nxt;
  logic [7:0]      hex_r, hex_nxt;
  logic            stop_r, stop_nxt;

  logic       is_pct, gather, have_ent, last;
  logic [4:0] hd;
  logic [7:0] mapped, ent_val, gat_val;
  logic       ent_ok, chr_ok;
  logic [7:0] chr_val;

  // Classify the byte
  always_comb begin
    last     = item.end_of_text;
    is_pct   = (item.in_byte == CH_PCT);
    hd       = hex_digit(item.in_byte);
    have_ent = (dc_r != '0);
    gather   = !is_pct && pend_r && is_alnum(item.in_byte) &&
               (dc_r < CntW'(ENTITY_MAX));
    mapped   = (item.in_byte == CH_PLUS) ? CH_SPACE : item.in_byte;
    // entity value once this byte is gathered
    gat_val  = (!stop_r && hd[4]) ? {hex_r[3:0], hd[3:0]} : hex_r;
  end

  // Next escape state
  always_comb begin
    pend_nxt = pend_r;
    dc_nxt   = dc_r;
    hex_nxt  = hex_r;
    stop_nxt = stop_r;
    if (is_pct) begin
      pend_nxt = have_ent || !pend_r;
      dc_nxt   = '0;
      hex_nxt  = 8'd0;
      stop_nxt = 1'b0;
    end else if (gather) begin
      if (!stop_r && hd[4]) begin
        hex_nxt = {hex_r[3:0], hd[3:0]};
      end else begin
        stop_nxt = 1'b1;
      end
      dc_nxt = dc_r + CntW'(1);
    end else if (have_ent) begin
      pend_nxt = 1'b0;
      dc_nxt   = '0;
      hex_nxt  = 8'd0;
      stop_nxt = 1'b0;
    end
    if (last) begin
      pend_nxt = 1'b0;
      dc_nxt   = '0;
      hex_nxt  = 8'd0;
      stop_nxt = 1'b0;
    end
  end

  // Emitted bytes: pending entity first, then the literal or raw byte
  always_comb begin
    ent_val = gather ? gat_val : hex_r;
    ent_ok  = ((have_ent && !gather) || (gather && last)) && (ent_val != 8'd0);
    chr_val = is_pct ? CH_PCT : mapped;
    if (is_pct) begin
      chr_ok = !have_ent && pend_r;
    end else begin
      chr_ok = !gather && (mapped != 8'd0);
    end
    res.n  = {1'b0, ent_ok} + {1'b0, chr_ok};
    res.b0 = ent_ok ? ent_val : chr_val;
    res.b1 = chr_val;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      dc_r   <= '0;
      hex_r  <= 8'd0;
      stop_r <= 1'b0;
    end else if (step) begin
      pend_r <= pend_nxt;
      dc_r   <= dc_nxt;
      hex_r  <= hex_nxt;
      stop_r <= stop_nxt;
    end
  end

  `PUD_ASSERT(a_dc_range, dc_r <= CntW'(ENTITY_MAX), "entity count beyond limit")
  `PUD_ASSERT(a_last_idle, step && item.end_of_text |=> !pend_r && dc_r == '0 && !stop_r,
              "state not cleared after end of text")
  `PUD_ASSERT(a_hold, !step |=> $stable(dc_r) && $stable(hex_r) && $stable(pend_r),
              "escape state moved without a step")

endmodule

/* rtl/core/percent_url_decoder.sv */
// Top level of the percent URL decoder: input register, decode, result queue.
//
//  channel | ports                            | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_stall, in_data      | in
//  result  | out_valid, out_stall, out_data   | out
//
// Each input byte is held in the input register, is decoded there and
// pushes zero, one or two results into a four-entry result queue.
// The input side takes one byte per cycle while the queue holds two or fewer
// results; the result port drains one per cycle while out_stall is low, so the
// sustained byte rate is set by the single result port.
// Synchronous active-low reset empties both stages and clears escape state.
// A stalled result port fills the queue and then stalls the input side.
`include "assert_macros.svh"
module percent_url_decoder
  import pud_pkg::*;
#(
  parameter int ENTITY_MAX = ENTITY_MAX_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  logic             in_vld_r, in_vld_nxt;
  in_t              in_r;
  logic             adv, in_take, pop;
  res_t             res;
  logic [1:0]       push_n;
  out_t             q_r [QDepth];
  logic [PtrW-1:0]  wr_r, rd_r;
  logic [QCntW-1:0] cnt_r, cnt_nxt;

  // Input register handshake
  assign adv      = in_vld_r && (cnt_r <= QCntW'(QDepth - 2));
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
  end

  // Decode
  pud_core #(
    .ENTITY_MAX(ENTITY_MAX)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (adv),
    .item (in_r),
    .res  (res)
  );

  assign push_n = adv ? res.n : 2'd0;

  // Result queue
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = q_r[rd_r];
  assign cnt_nxt   = cnt_r + QCntW'(push_n) - QCntW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PtrW'(push_n);
      rd_r  <= rd_r + PtrW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_r] <= '{out_byte: res.b0, run_last: (push_n == 2'd1)};
    end
    if (push_n == 2'd2) begin
      q_r[wr_r + PtrW'(1)] <= '{out_byte: res.b1, run_last: 1'b1};
    end
  end

  `PUD_ASSERT(a_q_bound, cnt_r <= QCntW'(QDepth), "result queue overflow")
  `PUD_ASSERT(a_in_hold, in_vld_r && !adv |=> in_vld_r && $stable(in_r),
              "held input item lost or changed")
  `PUD_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid && !in_vld_r,
                     "stages not empty after reset")

endmodule

/* verif/tb_top.sv */
// Testbench for the percent URL decoder: stimulus, decode prediction and result checking.
`timescale 1ns / 1ps

import pud_pkg::*;

// Predicts the decoded byte stream and matches it against the result channel
class decode_scoreboard;
  bit         escape_pending;
  bit   [1:0] digit_count;
  bit   [7:0] hex_value;
  bit         hex_stopped;
  bit   [7:0] step_bytes[$];
  out_t       expected_q[$];
  int         errors;

  function void clear_entity();
    digit_count = 2'd0;
    hex_value   = 8'd0;
    hex_stopped = 1'b0;
  endfunction

  // Zero bytes never appear in the decoded text; at most two per input byte
  function void push_byte(bit [7:0] b);
    if (b != 8'd0 && step_bytes.size() < 2) begin
      step_bytes.push_back(b);
    end
  endfunction

  function void flush_entity();
    push_byte(hex_value);
    clear_entity();
    escape_pending = 1'b0;
  endfunction

  // Called once per accepted input transfer
  function void note_input(in_t item);
    bit   [7:0] c;
    bit         word_char;
    int         nibble;
    out_t       res;
    c = item.in_byte;
    step_bytes.delete();
    word_char = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                (c >= "a" && c <= "z");
    nibble = -1;
    if (c >= "0" && c <= "9") begin
      nibble = c - "0";
    end else if (c >= "A" && c <= "F") begin
      nibble = c - "A" + 10;
    end else if (c >= "a" && c <= "f") begin
      nibble = c - "a" + 10;
    end

    if (c == CH_PCT) begin
      if (digit_count != 2'd0) begin
        // percent after an entity: flush it, open a new escape
        flush_entity();
        escape_pending = 1'b1;
      end else if (escape_pending) begin
        push_byte(CH_PCT);
        escape_pending = 1'b0;
      end else begin
        escape_pending = 1'b1;
      end
    end else if (escape_pending && word_char && digit_count < ENTITY_MAX_DEF) begin
      // gather into the entity; only the leading hex run counts
      if (!hex_stopped && nibble >= 0) begin
        hex_value = (hex_value << 4) | nibble[7:0];
      end else begin
        hex_stopped = 1'b1;
      end
      digit_count = digit_count + 2'd1;
    end else begin
      if (digit_count != 2'd0) begin
        flush_entity();
      end
      push_byte(c == CH_PLUS ? CH_SPACE : c);
    end

    // end of text flushes and returns to idle state
    if (item.end_of_text) begin
      if (digit_count != 2'd0) begin
        flush_entity();
      end
      escape_pending = 1'b0;
      clear_entity();
    end

    foreach (step_bytes[i]) begin
      res.out_byte = step_bytes[i];
      res.run_last = (i == step_bytes.size() - 1);
      expected_q.push_back(res);
    end
  endfunction

  task report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Called once per accepted result transfer
  task check_result(out_t got);
    out_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result byte %02h last %0b", got.out_byte, got.run_last));
    end else begin
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
      end
      if (got.run_last !== want.run_last) begin
        report($sformatf("run_last %0b, expected %0b (byte %02h)",
                         got.run_last, want.run_last, want.out_byte));
      end
    end
  endtask

  function int outstanding();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  decode_scoreboard sb;
  in_t  stim_q[$];
  bit   in_idle_on = 1'b1;
  logic out_stall_on = 1'b1;

  percent_url_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Random result-side stall
  always @(posedge clk) begin
    out_stall <= out_stall_on && ($urandom_range(99) < 25);
  end

  // Transfer monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_input(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
  end

  function automatic void add_byte(logic [7:0] b, logic eot = 1'b0);
    in_t item;
    item.in_byte     = b;
    item.end_of_text = eot;
    stim_q.push_back(item);
  endfunction

  function automatic logic [7:0] pick_hex();
    int r;
    r = $urandom_range(21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("A" + r - 10);
    return 8'("a" + r - 16);
  endfunction

  function automatic logic [7:0] pick_alnum();
    int r;
    r = $urandom_range(61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  // Drive one byte, with random idle cycles ahead of it
  task automatic send_byte(input in_t item);
    while (in_idle_on && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Run timeout
  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb = new;

    // Directed: plus, entity, percent after entity, entity full, double percent
    add_byte("+");
    add_byte("%"); add_byte("4"); add_byte("1");
    add_byte("%"); add_byte("4"); add_byte("2");
    add_byte("4");
    add_byte("%"); add_byte("%");
    // non-hex first digit gives zero; bare percent then punctuation
    add_byte("%"); add_byte("G"); add_byte("4"); add_byte("-");
    add_byte("%"); add_byte("/");
    add_byte("%");
    // zero byte, high byte, flush at end of text, trailing percent
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte("%"); add_byte("f"); add_byte("F", 1'b1);
    add_byte("%", 1'b1);

    // Random text: raw bytes, plus signs, well-formed and short escapes, percent runs
    while (stim_q.size() < 550) begin
      case ($urandom_range(9))
        0, 1: add_byte(8'($urandom_range(255)));
        2: add_byte(CH_PLUS);
        3, 4: begin
          add_byte(CH_PCT); add_byte(pick_hex()); add_byte(pick_hex());
        end
        5: begin
          add_byte(CH_PCT); add_byte(pick_alnum());
          if ($urandom_range(1)) add_byte(pick_alnum());
        end
        6: begin
          add_byte(CH_PCT); add_byte(CH_PCT);
        end
        7: begin
          add_byte(CH_PCT); add_byte(8'($urandom_range(255)));
        end
        8: add_byte(pick_alnum());
        default: begin
          repeat ($urandom_range(4, 1)) begin
            add_byte($urandom_range(2) == 0 ? CH_PCT : 8'($urandom_range(255)));
          end
        end
      endcase
      if ($urandom_range(9) == 0) stim_q[stim_q.size() - 1].end_of_text = 1'b1;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_q[i]) begin
      // stretch with no idling or stalling on either side
      in_idle_on   = !(i >= 250 && i < 400);
      out_stall_on <= in_idle_on;
      send_byte(stim_q[i]);
    end
    in_valid <= 1'b0;
    out_stall_on <= 1'b1;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
